// ===== hw/rtl/iklaw_pkg.sv =====
// Shared constants, types and helpers of the two-link inverse kinematics solver.
package iklaw_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int COORD_MAX       = 31;
    localparam int LEN_W           = 15;
    localparam int ANG_W           = 16;
    localparam int DIV_STEPS       = 15;
    localparam int CORDIC_STEPS    = 16;
    localparam int ACOS_SQ_W       = 30;
    localparam int CX_W            = 26;
    localparam int CZ_W            = 24;
    localparam int CFG_IDX_W       = 3;

    localparam logic signed [ANG_W-1:0] ONE_Q14     = 16'sd16384;
    localparam logic signed [ANG_W-1:0] PI_Q12      = 16'sd12868;
    localparam logic signed [CZ_W-1:0]  HALF_PI_Q20 = 24'sd1647099;

    localparam int ATAN_Q20 [CORDIC_STEPS] = '{
        823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32
    };

    localparam logic [CFG_IDX_W-1:0] REG_BASE_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_LEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REACH_LIMIT = 3'd5;

    localparam logic [LEN_W-1:0] UPPER_LEN_RST   = 15'd6144;
    localparam logic [LEN_W-1:0] LOWER_LEN_RST   = 15'd4096;
    localparam logic [LEN_W-1:0] REACH_LIMIT_RST = 15'd10240;

    typedef struct packed {
        logic reach;
        logic degen;
        logic ty_above;
    } t_ik_flags;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== hw/rtl/iklaw_sqrt_cell.sv =====
// One digit step of a restoring integer square root, registered.
module iklaw_sqrt_cell #(
    parameter int W    = 30,
    parameter int STEP = 0,
    parameter int TW   = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [W-1:0]  i_v,
    input  logic [W-1:0]  i_res,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [W-1:0]  o_v,
    output logic [W-1:0]  o_res,
    output logic [TW-1:0] o_tag
);
    localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * STEP);

    logic [W:0]    trial;
    logic          take;
    logic          r_vld;
    logic [W-1:0]  r_v;
    logic [W-1:0]  r_res;
    logic [TW-1:0] r_tag;

    assign trial = {1'b0, i_res} + {1'b0, BIT};
    assign take  = {1'b0, i_v} >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= take ? (i_v - trial[W-1:0]) : i_v;
        r_res <= take ? ((i_res >> 1) + BIT) : (i_res >> 1);
        r_tag <= i_tag;
    end

    assign o_vld = r_vld;
    assign o_v   = r_v;
    assign o_res = r_res;
    assign o_tag = r_tag;
endmodule

// ===== hw/rtl/iklaw_div_cell.sv =====
// One quotient bit of a restoring fraction divider, registered.
module iklaw_div_cell #(
    parameter int DW = 31,
    parameter int QW = 15,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [DW-1:0] i_r,
    input  logic [QW-1:0] i_q,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic          o_vld,
    output logic [DW-1:0] o_r,
    output logic [QW-1:0] o_q,
    output logic [DW-1:0] o_den,
    output logic [TW-1:0] o_tag
);
    logic [DW:0]   shl;
    logic [DW:0]   diff;
    logic          take;
    logic          r_vld;
    logic [DW-1:0] r_r;
    logic [QW-1:0] r_q;
    logic [DW-1:0] r_den;
    logic [TW-1:0] r_tag;

    assign shl  = {i_r, 1'b0};
    assign diff = shl - {1'b0, i_den};
    assign take = shl >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r   <= take ? diff[DW-1:0] : shl[DW-1:0];
        r_q   <= {i_q[QW-2:0], take};
        r_den <= i_den;
        r_tag <= i_tag;
    end

    assign o_vld = r_vld;
    assign o_r   = r_r;
    assign o_q   = r_q;
    assign o_den = r_den;
    assign o_tag = r_tag;
endmodule

// ===== hw/rtl/iklaw_cordic_cell.sv =====
// One CORDIC vectoring micro-rotation, registered.
module iklaw_cordic_cell #(
    parameter int STEP = 0,
    parameter int XW   = 26,
    parameter int ZW   = 24,
    parameter int TW   = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  logic [TW-1:0]        i_tag,
    output logic                 o_vld,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output logic [TW-1:0]        o_tag
);
    localparam logic signed [ZW-1:0] ANG = ZW'(iklaw_pkg::ATAN_Q20[STEP]);

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic                 y_pos;
    logic                 r_vld;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [TW-1:0]        r_tag;

    assign xs    = i_x >>> STEP;
    assign ys    = i_y >>> STEP;
    // y == 0 rotates as if negative
    assign y_pos = !i_y[XW-1] && (i_y != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= y_pos ? (i_x + ys) : (i_x - ys);
        r_y   <= y_pos ? (i_y - xs) : (i_y + xs);
        r_z   <= y_pos ? (i_z + ANG) : (i_z - ANG);
        r_tag <= i_tag;
    end

    assign o_vld = r_vld;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_tag = r_tag;
endmodule

// ===== hw/rtl/iklaw_angle.sv =====
// Ratio (pos - neg) / den saturated to +-1, then acos via square root and CORDIC.
module iklaw_angle #(
    parameter int NW = 35,
    parameter int DW = 33,
    parameter int TW = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_vld,
    input  logic [NW-1:0]                         i_pos,
    input  logic [NW-1:0]                         i_neg,
    input  logic [DW-1:0]                         i_den,
    input  logic [TW-1:0]                         i_tag,
    output logic                                  o_vld,
    output logic signed [iklaw_pkg::ANG_W-1:0]    o_angle,
    output logic                                  o_clamp,
    output logic [TW-1:0]                         o_tag
);
    localparam int MW   = iklaw_pkg::imax(NW, DW);
    localparam int QW   = iklaw_pkg::DIV_STEPS;
    localparam int AW   = iklaw_pkg::ANG_W;
    localparam int SW   = iklaw_pkg::ACOS_SQ_W;
    localparam int SN   = SW / 2;
    localparam int XW   = iklaw_pkg::CX_W;
    localparam int ZW   = iklaw_pkg::CZ_W;
    localparam int CN   = iklaw_pkg::CORDIC_STEPS;
    localparam int ETW  = TW + 4;
    localparam int STW  = TW + 1 + AW;
    localparam int CTW  = TW + 1;
    localparam logic [SW-1:0] ONE_SQ = {{(SW-1){1'b0}}, 1'b1} << (2 * (AW - 2));

    // entry: sign, magnitude, saturation
    logic          negative;
    logic [NW-1:0] mag;
    logic [MW-1:0] mag_x;
    logic [MW-1:0] den_x;
    logic          r_e_vld;
    logic [DW-1:0] r_e_r;
    logic [DW-1:0] r_e_den;
    logic [ETW-1:0] r_e_tag;

    assign negative = i_neg > i_pos;
    assign mag      = negative ? (i_neg - i_pos) : (i_pos - i_neg);
    assign mag_x    = MW'(mag);
    assign den_x    = MW'(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_r   <= mag_x[DW-1:0];
        r_e_den <= i_den;
        r_e_tag <= {i_tag, negative, (mag_x >= den_x) && (mag != '0), mag == '0,
                    mag_x > den_x};
    end

    // divider chain
    logic           d_vld [0:QW];
    logic [DW-1:0]  d_r   [0:QW];
    logic [QW-1:0]  d_q   [0:QW];
    logic [DW-1:0]  d_den [0:QW];
    logic [ETW-1:0] d_tag [0:QW];

    assign d_vld[0] = r_e_vld;
    assign d_r[0]   = r_e_r;
    assign d_q[0]   = '0;
    assign d_den[0] = r_e_den;
    assign d_tag[0] = r_e_tag;

    for (genvar g = 0; g < QW; g++) begin : g_div
        iklaw_div_cell #(.DW(DW), .QW(QW), .TW(ETW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(d_vld[g]), .i_r(d_r[g]), .i_q(d_q[g]), .i_den(d_den[g]),
            .i_tag(d_tag[g]),
            .o_vld(d_vld[g+1]), .o_r(d_r[g+1]), .o_q(d_q[g+1]), .o_den(d_den[g+1]),
            .o_tag(d_tag[g+1])
        );
    end

    // round to Q2.14 and apply sign
    logic [TW-1:0]  q_tag;
    logic           q_neg;
    logic           q_sat;
    logic           q_zero;
    logic           q_clamp;
    logic [QW:0]    q_round;
    logic [AW-1:0]  q_mag;
    logic           r_a_vld;
    logic signed [AW-1:0] r_a;
    logic [TW-1:0]  r_a_tag;
    logic           r_a_clamp;

    assign {q_tag, q_neg, q_sat, q_zero, q_clamp} = d_tag[QW];
    assign q_round = ({1'b0, d_q[QW]} + 1'b1) >> 1;
    assign q_mag   = q_sat  ? iklaw_pkg::ONE_Q14 :
                     q_zero ? '0 : AW'(q_round);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= d_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= q_neg ? -$signed(q_mag) : $signed(q_mag);
        r_a_tag   <= q_tag;
        r_a_clamp <= q_clamp;
    end

    // a squared
    logic signed [2*AW-1:0] a_prod;
    logic           r_b_vld;
    logic [SW-2:0]  r_b_a2;
    logic signed [AW-1:0] r_b_a;
    logic [TW-1:0]  r_b_tag;
    logic           r_b_clamp;

    assign a_prod = r_a * r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_a2    <= a_prod[SW-2:0];
        r_b_a     <= r_a;
        r_b_tag   <= r_a_tag;
        r_b_clamp <= r_a_clamp;
    end

    // s = sqrt(1 - a^2)
    logic           s_vld [0:SN];
    logic [SW-1:0]  s_v   [0:SN];
    logic [SW-1:0]  s_res [0:SN];
    logic [STW-1:0] s_tag [0:SN];

    assign s_vld[0] = r_b_vld;
    assign s_v[0]   = ONE_SQ - {1'b0, r_b_a2};
    assign s_res[0] = '0;
    assign s_tag[0] = {r_b_tag, r_b_clamp, r_b_a};

    for (genvar g = 0; g < SN; g++) begin : g_sqrt
        iklaw_sqrt_cell #(.W(SW), .STEP(g), .TW(STW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(s_vld[g]), .i_v(s_v[g]), .i_res(s_res[g]), .i_tag(s_tag[g]),
            .o_vld(s_vld[g+1]), .o_v(s_v[g+1]), .o_res(s_res[g+1]), .o_tag(s_tag[g+1])
        );
    end

    // CORDIC start vector, pre-rotated by -pi/2 for negative a
    logic signed [AW-1:0] s_a;
    logic [CTW-1:0]       s_rest;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;
    logic                 r_c_vld;
    logic signed [XW-1:0] r_c_x;
    logic signed [XW-1:0] r_c_y;
    logic signed [ZW-1:0] r_c_z;
    logic [CTW-1:0]       r_c_tag;

    assign {s_rest, s_a} = s_tag[SN];
    assign x0 = XW'(s_a) <<< 8;
    assign y0 = $signed(XW'(s_res[SN])) <<< 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= s_vld[SN];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_a[AW-1]) begin
            r_c_x <= y0;
            r_c_y <= -x0;
            r_c_z <= iklaw_pkg::HALF_PI_Q20;
        end else begin
            r_c_x <= x0;
            r_c_y <= y0;
            r_c_z <= '0;
        end
        r_c_tag <= s_rest;
    end

    logic                 c_vld [0:CN];
    logic signed [XW-1:0] c_x   [0:CN];
    logic signed [XW-1:0] c_y   [0:CN];
    logic signed [ZW-1:0] c_z   [0:CN];
    logic [CTW-1:0]       c_tag [0:CN];

    assign c_vld[0] = r_c_vld;
    assign c_x[0]   = r_c_x;
    assign c_y[0]   = r_c_y;
    assign c_z[0]   = r_c_z;
    assign c_tag[0] = r_c_tag;

    for (genvar g = 0; g < CN; g++) begin : g_cordic
        iklaw_cordic_cell #(.STEP(g), .XW(XW), .ZW(ZW), .TW(CTW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(c_vld[g]), .i_x(c_x[g]), .i_y(c_y[g]), .i_z(c_z[g]),
            .i_tag(c_tag[g]),
            .o_vld(c_vld[g+1]), .o_x(c_x[g+1]), .o_y(c_y[g+1]), .o_z(c_z[g+1]),
            .o_tag(c_tag[g+1])
        );
    end

    // Q.20 -> Q4.12, round half up
    logic signed [ZW-1:0] z_rnd;
    logic signed [ZW-1:0] z_shr;
    logic                 r_o_vld;
    logic signed [AW-1:0] r_o_angle;
    logic                 r_o_clamp;
    logic [TW-1:0]        r_o_tag;

    assign z_rnd = c_z[CN] + ZW'(128);
    assign z_shr = z_rnd >>> 8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= c_vld[CN];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_angle           <= z_shr[AW-1:0];
        {r_o_tag, r_o_clamp} <= c_tag[CN];
    end

    assign o_vld   = r_o_vld;
    assign o_angle = r_o_angle;
    assign o_clamp = r_o_clamp;
    assign o_tag   = r_o_tag;
endmodule

// ===== hw/rtl/two_link_analytic_ik.sv =====
// Two-link planar IK top (COORD_WIDTH clipped at 31): from start to o_valid a target passes
// the offset and square stages, the distance root chain, the divider, the acos root
// and the CORDIC chain, each chain built of registered cells.
// Throughput one word per cycle; busy is always low and results cannot be stalled.
// Synchronous active-low reset clears the pipeline valids and loads register defaults.
module two_link_analytic_ik #(
    parameter int COORD_WIDTH = iklaw_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [COORD_WIDTH-1:0]                 i_target_x,
    input  logic [COORD_WIDTH-1:0]                 i_target_y,
    input  logic [COORD_WIDTH-1:0]                 i_target_z,
    input  logic                                   i_cfg_we,
    input  logic [iklaw_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [iklaw_pkg::imax(COORD_WIDTH, iklaw_pkg::LEN_W)-1:0] i_cfg_data,
    output logic                                   o_valid,
    output logic                                   o_reachable,
    output logic                                   o_clamped,
    output logic                                   o_degenerate,
    output logic signed [iklaw_pkg::ANG_W-1:0]     o_shoulder_angle,
    output logic signed [iklaw_pkg::ANG_W-1:0]     o_elbow_angle
);
    localparam int CW   = (COORD_WIDTH > iklaw_pkg::COORD_MAX) ? iklaw_pkg::COORD_MAX
                                                               : COORD_WIDTH;
    localparam int LW   = iklaw_pkg::LEN_W;
    localparam int AW   = iklaw_pkg::ANG_W;
    localparam int DW1  = CW + 1;
    localparam int D2W  = 2 * CW + 2;
    localparam int SQN  = D2W / 2;
    // sums wrap at 64 bits at the widest coordinates
    localparam int NW   = (D2W >= 64) ? 64 : iklaw_pkg::imax(D2W, 31) + 1;
    localparam int DENW = iklaw_pkg::imax(DW1 + LW + 1, 31);
    localparam int FW   = $bits(iklaw_pkg::t_ik_flags);
    localparam int QTW  = FW + 1 + DW1 + D2W;

    assign busy = 1'b0;

    // configuration registers
    logic signed [CW-1:0] r_base_x;
    logic signed [CW-1:0] r_base_y;
    logic signed [CW-1:0] r_base_z;
    logic [LW-1:0]        r_upper;
    logic [LW-1:0]        r_lower;
    logic [LW-1:0]        r_reach;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x <= '0;
            r_base_y <= '0;
            r_base_z <= '0;
            r_upper  <= iklaw_pkg::UPPER_LEN_RST;
            r_lower  <= iklaw_pkg::LOWER_LEN_RST;
            r_reach  <= iklaw_pkg::REACH_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                iklaw_pkg::REG_BASE_X:      r_base_x <= i_cfg_data[CW-1:0];
                iklaw_pkg::REG_BASE_Y:      r_base_y <= i_cfg_data[CW-1:0];
                iklaw_pkg::REG_BASE_Z:      r_base_z <= i_cfg_data[CW-1:0];
                iklaw_pkg::REG_UPPER_LEN:   r_upper  <= i_cfg_data[LW-1:0];
                iklaw_pkg::REG_LOWER_LEN:   r_lower  <= i_cfg_data[LW-1:0];
                iklaw_pkg::REG_REACH_LIMIT: r_reach  <= i_cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    // products of the lengths, refreshed every cycle
    logic [2*LW-1:0] r_u2;
    logic [2*LW-1:0] r_l2;
    logic [2*LW:0]   r_ul2;
    logic [2*LW-1:0] r_rl2;
    logic [2*LW-1:0] ul_prod;

    assign ul_prod = r_upper * r_lower;

    always_ff @(posedge i_clk) begin
        r_u2  <= r_upper * r_upper;
        r_l2  <= r_lower * r_lower;
        r_ul2 <= {ul_prod, 1'b0};
        r_rl2 <= r_reach * r_reach;
    end

    // stage 1: offsets from target to base
    logic signed [CW-1:0]  tx;
    logic signed [CW-1:0]  ty;
    logic signed [CW-1:0]  tz;
    logic                  r1_vld;
    logic signed [DW1-1:0] r1_dx;
    logic signed [DW1-1:0] r1_dy;
    logic signed [DW1-1:0] r1_dz;
    logic                  r1_ty_above;

    assign tx = i_target_x[CW-1:0];
    assign ty = i_target_y[CW-1:0];
    assign tz = i_target_z[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dx       <= DW1'(r_base_x) - DW1'(tx);
        r1_dy       <= DW1'(r_base_y) - DW1'(ty);
        r1_dz       <= DW1'(r_base_z) - DW1'(tz);
        r1_ty_above <= ty > r_base_y;
    end

    // stage 2: magnitudes squared
    logic [DW1-1:0] ax;
    logic [DW1-1:0] ay;
    logic [DW1-1:0] az;
    logic           r2_vld;
    logic [D2W-1:0] r2_sx2;
    logic [D2W-1:0] r2_sy2;
    logic [D2W-1:0] r2_sz2;
    logic [DW1-1:0] r2_ax;
    logic           r2_dxneg;
    logic           r2_ty_above;

    assign ax = r1_dx[DW1-1] ? $unsigned(-r1_dx) : $unsigned(r1_dx);
    assign ay = r1_dy[DW1-1] ? $unsigned(-r1_dy) : $unsigned(r1_dy);
    assign az = r1_dz[DW1-1] ? $unsigned(-r1_dz) : $unsigned(r1_dz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_sx2      <= ax * ax;
        r2_sy2      <= ay * ay;
        r2_sz2      <= az * az;
        r2_ax       <= ax;
        r2_dxneg    <= r1_dx[DW1-1];
        r2_ty_above <= r1_ty_above;
    end

    // stage 3: planar sum
    logic           r3_vld;
    logic [D2W-1:0] r3_sxy;
    logic [D2W-1:0] r3_sz2;
    logic [DW1-1:0] r3_ax;
    logic           r3_dxneg;
    logic           r3_ty_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_sxy      <= r2_sx2 + r2_sy2;
        r3_sz2      <= r2_sz2;
        r3_ax       <= r2_ax;
        r3_dxneg    <= r2_dxneg;
        r3_ty_above <= r2_ty_above;
    end

    // stage 4: 3D distance squared
    logic           r4_vld;
    logic [D2W-1:0] r4_d2;
    logic [D2W-1:0] r4_sxy;
    logic [DW1-1:0] r4_ax;
    logic           r4_dxneg;
    logic           r4_ty_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_d2       <= r3_sxy + r3_sz2;
        r4_sxy      <= r3_sxy;
        r4_ax       <= r3_ax;
        r4_dxneg    <= r3_dxneg;
        r4_ty_above <= r3_ty_above;
    end

    // distance root chain
    iklaw_pkg::t_ik_flags flags_in;

    assign flags_in.reach    = NW'(r4_d2) < NW'(r_rl2);
    assign flags_in.degen    = r4_d2 == '0;
    assign flags_in.ty_above = r4_ty_above;

    logic           q_vld [0:SQN];
    logic [D2W-1:0] q_v   [0:SQN];
    logic [D2W-1:0] q_res [0:SQN];
    logic [QTW-1:0] q_tag [0:SQN];

    assign q_vld[0] = r4_vld;
    assign q_v[0]   = r4_d2;
    assign q_res[0] = '0;
    assign q_tag[0] = {flags_in, r4_dxneg, r4_ax, r4_sxy};

    for (genvar g = 0; g < SQN; g++) begin : g_dist
        iklaw_sqrt_cell #(.W(D2W), .STEP(g), .TW(QTW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_vld(q_vld[g]), .i_v(q_v[g]), .i_res(q_res[g]), .i_tag(q_tag[g]),
            .o_vld(q_vld[g+1]), .o_v(q_v[g+1]), .o_res(q_res[g+1]), .o_tag(q_tag[g+1])
        );
    end

    // stage M: acos operands
    iklaw_pkg::t_ik_flags q_flags;
    logic                 q_dxneg;
    logic [DW1-1:0]       q_ax;
    logic [D2W-1:0]       q_sxy;
    logic [DW1-1:0]       q_d;
    logic [DW1+LW:0]      ud2;

    assign {q_flags, q_dxneg, q_ax, q_sxy} = q_tag[SQN];
    assign q_d = q_res[SQN][DW1-1:0];
    assign ud2 = {r_upper, 1'b0} * q_d;

    logic                 rm_vld;
    iklaw_pkg::t_ik_flags rm_flags;
    logic [NW-1:0]        rm_pos1;
    logic [NW-1:0]        rm_neg1;
    logic [DENW-1:0]      rm_den1;
    logic [NW-1:0]        rm_pos2;
    logic [NW-1:0]        rm_neg2;
    logic [DENW-1:0]      rm_den2;
    logic [NW-1:0]        rm_pos3;
    logic [NW-1:0]        rm_neg3;
    logic [DENW-1:0]      rm_den3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_vld <= 1'b0;
        end else begin
            rm_vld <= q_vld[SQN];
        end
    end

    always_ff @(posedge i_clk) begin
        rm_flags <= q_flags;
        rm_pos1  <= q_dxneg ? '0 : NW'(q_ax);
        rm_neg1  <= q_dxneg ? NW'(q_ax) : '0;
        rm_den1  <= DENW'(q_d);
        rm_pos2  <= NW'(r_u2) + NW'(q_sxy);
        rm_neg2  <= NW'(r_l2);
        rm_den2  <= DENW'(ud2);
        rm_pos3  <= NW'(r_u2) + NW'(r_l2);
        rm_neg3  <= NW'(q_sxy);
        rm_den3  <= DENW'(r_ul2);
    end

    // three acos units in lockstep; each carries one flag
    logic                 v1, v2, v3;
    logic signed [AW-1:0] a1, a2, a3;
    logic                 c1, c2, c3;
    logic                 f_above, f_reach, f_degen;

    iklaw_angle #(.NW(NW), .DW(DENW), .TW(1)) u_dir (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(rm_vld),
        .i_pos(rm_pos1), .i_neg(rm_neg1), .i_den(rm_den1), .i_tag(rm_flags.ty_above),
        .o_vld(v1), .o_angle(a1), .o_clamp(c1), .o_tag(f_above)
    );

    iklaw_angle #(.NW(NW), .DW(DENW), .TW(1)) u_shoulder (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(rm_vld),
        .i_pos(rm_pos2), .i_neg(rm_neg2), .i_den(rm_den2), .i_tag(rm_flags.reach),
        .o_vld(v2), .o_angle(a2), .o_clamp(c2), .o_tag(f_reach)
    );

    iklaw_angle #(.NW(NW), .DW(DENW), .TW(1)) u_elbow (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(rm_vld),
        .i_pos(rm_pos3), .i_neg(rm_neg3), .i_den(rm_den3), .i_tag(rm_flags.degen),
        .o_vld(v3), .o_angle(a3), .o_clamp(c3), .o_tag(f_degen)
    );

    // output word
    logic                 r_valid;
    logic                 r_reachable;
    logic                 r_clamped;
    logic                 r_degenerate;
    logic signed [AW-1:0] r_shoulder;
    logic signed [AW-1:0] r_elbow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= v1 && v2 && v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_reachable  <= f_reach;
        r_degenerate <= f_degen;
        priority if (f_degen) begin
            r_clamped  <= 1'b0;
            r_shoulder <= '0;
            r_elbow    <= '0;
        end else if (!f_reach) begin
            // straight arm pointing at the target
            r_clamped  <= c1;
            r_shoulder <= f_above ? -a1 : a1;
            r_elbow    <= '0;
        end else begin
            r_clamped  <= c1 || c2 || c3;
            r_shoulder <= a2 + a1;
            r_elbow    <= a3 + iklaw_pkg::PI_Q12;
        end
    end

    assign o_valid          = r_valid;
    assign o_reachable      = r_reachable;
    assign o_clamped        = r_clamped;
    assign o_degenerate     = r_degenerate;
    assign o_shoulder_angle = r_shoulder;
    assign o_elbow_angle    = r_elbow;
endmodule

// ===== sim/two_link_analytic_ik_tb.sv =====
// Testbench for the two-link analytic IK solver: random and directed targets, predicted angles.
module two_link_analytic_ik_tb;

    localparam int CW        = 16;
    localparam int LATENCY   = CW + 58;
    localparam int WDOG_MAX  = 4000;
    localparam int N_PHASES  = 6;

    typedef struct {
        logic        reach;
        logic        clamp;
        logic        degen;
        logic [15:0] shoulder;
        logic [15:0] elbow;
    } t_ik_answer;

    class ik_scoreboard;
        t_ik_answer  expected_angles[$];
        int          errors;
        longint      base_x, base_y, base_z;
        longint unsigned upper, lower, reach_lim;

        function new();
            errors = 0;
            base_x = 0;
            base_y = 0;
            base_z = 0;
            upper = iklaw_pkg::UPPER_LEN_RST;
            lower = iklaw_pkg::LOWER_LEN_RST;
            reach_lim = iklaw_pkg::REACH_LIMIT_RST;
        endfunction

        function void set_reg(logic [iklaw_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
            case (idx)
                iklaw_pkg::REG_BASE_X:      base_x = longint'($signed(data));
                iklaw_pkg::REG_BASE_Y:      base_y = longint'($signed(data));
                iklaw_pkg::REG_BASE_Z:      base_z = longint'($signed(data));
                iklaw_pkg::REG_UPPER_LEN:   upper = data[14:0];
                iklaw_pkg::REG_LOWER_LEN:   lower = data[14:0];
                iklaw_pkg::REG_REACH_LIMIT: reach_lim = data[14:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // signed Q2.14 quotient (pos - neg) / den, saturating at +-1
        function longint ratio_q14(longint unsigned pos, longint unsigned neg,
                                   longint unsigned den, inout bit clamp);
            bit              negative;
            longint unsigned mag, r, q;
            negative = neg > pos;
            mag = negative ? neg - pos : pos - neg;
            q = 0;
            if (den == 0) begin
                if (mag == 0) return 0;
                clamp = 1;
                return negative ? -16384 : 16384;
            end
            if (mag > den) begin
                clamp = 1;
                return negative ? -16384 : 16384;
            end
            if (mag == den) return negative ? -16384 : 16384;
            r = mag;
            for (int i = 0; i < 15; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r = r - den;
                    q = q | 1;
                end
            end
            q = (q + 1) >> 1;
            return negative ? -longint'(q) : longint'(q);
        endfunction

        function longint acos_q12(longint a);
            longint s, x, y, z, nx;
            s = longint'(int_sqrt(longint'(64'd1 << 28) - a * a));
            x = a * 256;
            y = s * 256;
            z = 0;
            if (a < 0) begin
                nx = y;
                y = -x;
                x = nx;
                z = longint'(iklaw_pkg::HALF_PI_Q20);
            end
            for (int i = 0; i < iklaw_pkg::CORDIC_STEPS; i++) begin
                if (y > 0) begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + iklaw_pkg::ATAN_Q20[i];
                end else begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - iklaw_pkg::ATAN_Q20[i];
                end
                x = nx;
            end
            return (z + 128) >>> 8;
        endfunction

        function t_ik_answer solve_ik(logic [15:0] tx_b, logic [15:0] ty_b, logic [15:0] tz_b);
            t_ik_answer      ans;
            longint          tx, ty, tz, dx, dy, dz, sh, el, tt;
            longint unsigned ax, ay, az, sxy, d2, d;
            bit              clamp;
            tx = longint'($signed(tx_b));
            ty = longint'($signed(ty_b));
            tz = longint'($signed(tz_b));
            dx = base_x - tx;
            dy = base_y - ty;
            dz = base_z - tz;
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            az = dz < 0 ? -dz : dz;
            sxy = ax * ax + ay * ay;
            d2 = sxy + az * az;
            clamp = 0;
            ans.reach = d2 < reach_lim * reach_lim;
            ans.degen = 0;
            if (d2 == 0) begin
                ans.clamp = 0;
                ans.degen = 1;
                ans.shoulder = 0;
                ans.elbow = 0;
                return ans;
            end
            d = int_sqrt(d2);
            tt = acos_q12(ratio_q14(dx >= 0 ? ax : 0, dx < 0 ? ax : 0, d, clamp));
            if (!ans.reach) begin
                sh = (ty > base_y) ? -tt : tt;
                el = 0;
            end else begin
                sh = acos_q12(ratio_q14(upper * upper + sxy, lower * lower,
                                        2 * upper * d, clamp)) + tt;
                el = acos_q12(ratio_q14(upper * upper + lower * lower, sxy,
                                        2 * upper * lower, clamp))
                     + longint'(iklaw_pkg::PI_Q12);
            end
            ans.clamp = clamp;
            ans.shoulder = sh[15:0];
            ans.elbow = el[15:0];
            return ans;
        endfunction

        function void note_target(logic [15:0] tx, logic [15:0] ty, logic [15:0] tz);
            expected_angles.push_back(solve_ik(tx, ty, tz));
        endfunction

        function void check_angles(t_ik_answer got);
            t_ik_answer exp_a;
            if (expected_angles.size() == 0) begin
                $error("unexpected result word");
                errors++;
                return;
            end
            exp_a = expected_angles.pop_front();
            if (got.reach !== exp_a.reach) begin
                $error("reachable: expected %0d, got %0d", exp_a.reach, got.reach);
                errors++;
            end
            if (got.clamp !== exp_a.clamp) begin
                $error("clamped: expected %0d, got %0d", exp_a.clamp, got.clamp);
                errors++;
            end
            if (got.degen !== exp_a.degen) begin
                $error("degenerate: expected %0d, got %0d", exp_a.degen, got.degen);
                errors++;
            end
            if (got.shoulder !== exp_a.shoulder) begin
                $error("shoulder_angle: expected %0d, got %0d",
                       $signed(exp_a.shoulder), $signed(got.shoulder));
                errors++;
            end
            if (got.elbow !== exp_a.elbow) begin
                $error("elbow_angle: expected %0d, got %0d",
                       $signed(exp_a.elbow), $signed(got.elbow));
                errors++;
            end
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [CW-1:0]                      i_target_x, i_target_y, i_target_z;
    logic                               i_cfg_we;
    logic [iklaw_pkg::CFG_IDX_W-1:0]    i_cfg_idx;
    logic [15:0]                        i_cfg_data;
    logic                               o_valid, o_reachable, o_clamped, o_degenerate;
    logic signed [iklaw_pkg::ANG_W-1:0] o_shoulder_angle, o_elbow_angle;

    ik_scoreboard angle_sb;
    int           sent_count;
    int           idle_cycles;

    two_link_analytic_ik #(.COORD_WIDTH(CW)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_target_x(i_target_x), .i_target_y(i_target_y), .i_target_z(i_target_z),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_reachable(o_reachable), .o_clamped(o_clamped),
        .o_degenerate(o_degenerate), .o_shoulder_angle(o_shoulder_angle),
        .o_elbow_angle(o_elbow_angle)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        t_ik_answer got;
        if (i_rst_n && o_valid) begin
            got.reach = o_reachable;
            got.clamp = o_clamped;
            got.degen = o_degenerate;
            got.shoulder = o_shoulder_angle;
            got.elbow = o_elbow_angle;
            angle_sb.check_angles(got);
        end
    end

    // watchdog: cycles without any accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [iklaw_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        angle_sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(logic [15:0] bx, logic [15:0] by, logic [15:0] bz,
                             logic [15:0] ul, logic [15:0] ll, logic [15:0] rl);
        write_reg(iklaw_pkg::REG_BASE_X, bx);
        write_reg(iklaw_pkg::REG_BASE_Y, by);
        write_reg(iklaw_pkg::REG_BASE_Z, bz);
        write_reg(iklaw_pkg::REG_UPPER_LEN, ul);
        write_reg(iklaw_pkg::REG_LOWER_LEN, ll);
        write_reg(iklaw_pkg::REG_REACH_LIMIT, rl);
    endtask

    task automatic send_target(logic [15:0] tx, logic [15:0] ty, logic [15:0] tz);
        int gap_pct;
        gap_pct = (sent_count < 400) ? 32 : (sent_count < 800) ? 67 : 0;
        @(negedge i_clk);
        start <= 1'b1;
        i_target_x <= tx;
        i_target_y <= ty;
        i_target_z <= tz;
        do @(posedge i_clk); while (busy);
        angle_sb.note_target(tx, ty, tz);
        sent_count++;
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // hold off until every word is back, then let the pipe empty out
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (angle_sb.expected_angles.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic send_random(int n);
        logic [15:0] bx, by, bz, off_max;
        int          sel;
        bx = angle_sb.base_x[15:0];
        by = angle_sb.base_y[15:0];
        bz = angle_sb.base_z[15:0];
        off_max = (angle_sb.reach_lim > 200) ? 16'(angle_sb.reach_lim[14:0] + 2000)
                                             : 16'd3000;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (sel < 5) begin
                send_target(bx, by, bz);
            end else if (sel < 75) begin
                send_target(bx + 16'($urandom_range(2 * off_max) - off_max),
                            by + 16'($urandom_range(2 * off_max) - off_max),
                            bz + 16'($urandom_range(off_max / 4) - off_max / 8));
            end else begin
                send_target(16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        angle_sb = new();
        sent_count = 0;
        start = 1'b0;
        i_target_x = '0;
        i_target_y = '0;
        i_target_z = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed targets at reset settings
        send_target(16'd0, 16'd0, 16'd0);
        send_target(16'sd32767, 16'd0, 16'd0);
        send_target(-16'sd32768, 16'd0, 16'd0);
        send_target(16'd0, 16'sd32767, 16'd0);
        send_target(16'd0, -16'sd32768, 16'd0);
        send_target(16'd0, 16'd0, 16'sd32767);
        send_target(16'd0, 16'd0, -16'sd32768);
        send_target(16'sd32767, 16'sd32767, 16'sd32767);
        send_target(-16'sd32768, -16'sd32768, -16'sd32768);
        send_target(16'sd4096, 16'd0, 16'd0);
        send_target(-16'sd4096, 16'd0, 16'd0);
        send_target(16'd0, 16'sd4096, 16'd0);
        send_target(16'd0, -16'sd4096, 16'd0);
        send_target(16'sd10240, 16'd0, 16'd0);
        send_target(16'sd10239, 16'd0, 16'd0);
        send_target(16'sd2048, 16'd0, 16'd0);
        send_target(16'sd1024, 16'd0, 16'd0);
        send_target(16'd0, 16'd0, 16'sd4096);
        send_target(-16'sd6000, 16'sd3000, 16'sd100);
        send_target(16'sd3000, -16'sd7000, -16'sd200);
        send_random(150);
        drain();

        // out-of-range index must be ignored
        write_reg(3'd6, 16'hBEEF);
        for (int ph = 1; ph < N_PHASES; ph++) begin
            case (ph)
                1: write_all(16'd0, 16'd0, 16'd0, 16'd8192, 16'd6144, 16'd14000);
                2: write_all(16'h8000, 16'h7FFF, 16'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
                3: write_all(16'd1234, -16'sd2000, 16'd500, 16'd0, 16'd4096, 16'd3000);
                4: write_all(16'd0, 16'd0, 16'd0, 16'd4096, 16'd0, 16'd0);
                default: write_all(16'($urandom), 16'($urandom), 16'($urandom),
                                   16'($urandom_range(32767)), 16'($urandom_range(32767)),
                                   16'($urandom_range(32767)));
            endcase
            send_target(angle_sb.base_x[15:0], angle_sb.base_y[15:0], angle_sb.base_z[15:0]);
            send_random(210);
            drain();
        end

        if (angle_sb.errors == 0 && angle_sb.expected_angles.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
